FILE: hw/rtl/divisor_count_trial_division_unit_macros.svh
// Assertion macros for the divisor count block.
// DCTD_ASSERT_IMP checks a consequent in the same cycle as its antecedent,
// DCTD_ASSERT_NXT checks it in the cycle after.
`ifndef DIVISOR_COUNT_TRIAL_DIVISION_UNIT_MACROS_SVH
`define DIVISOR_COUNT_TRIAL_DIVISION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DCTD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("dctd assertion failed");
`define DCTD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("dctd assertion failed");
`else
`define DCTD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DCTD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/dctd_pkg.sv
package dctd_pkg;

	localparam int COUNT_WIDTH = 11;

	// Count increments: a divisor below the root stands for a pair,
	// the exact root of a square for one divisor only.
	localparam logic [COUNT_WIDTH-1:0] CNT_PAIR   = COUNT_WIDTH'(2);
	localparam logic [COUNT_WIDTH-1:0] CNT_SQUARE = COUNT_WIDTH'(1);

	// Status from the remainder unit back to the sequencer.
	typedef struct packed {
		logic done;
		logic is_zero;
	} rem_rsp_t;

endpackage

FILE: hw/rtl/dctd_in_if.sv
interface dctd_in_if #(
	parameter int VALUE_WIDTH = 31
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

FILE: hw/rtl/dctd_out_if.sv
interface dctd_out_if;
	logic                            valid;
	logic                            ready;
	logic [dctd_pkg::COUNT_WIDTH-1:0] divisor_count;
	logic                            is_prime;

	modport source (output valid, output divisor_count, output is_prime, input ready);
	modport sink   (input valid, input divisor_count, input is_prime, output ready);
endinterface

FILE: hw/rtl/divisor_count_trial_division_unit.sv
// Divisor counter with primality flag, by trial division. Each input beat
// carries one unsigned value of VALUE_WIDTH bits; each output beat returns
// how many positive divisors it has (0 for zero, 1 for one) and whether it
// is prime (greater than one with exactly two divisors). Candidates run
// from 1 upward while cand*cand <= value; the square is kept by adding
// 2*cand+1, so no multiplier is needed. Every candidate goes through one
// shared bit-serial remainder unit, started from the check state and
// waited on in the divide state. The input is ready only while no item
// is in work; a finished result sits in an output register, so the next
// value may be taken while that result waits to be read.
`include "divisor_count_trial_division_unit_macros.svh"

module divisor_count_trial_division_unit #(
	parameter int VALUE_WIDTH = 31
) (
	input  logic          clk,
	input  logic          arst_n,
	dctd_in_if.sink       req,
	dctd_out_if.source    rsp
);

	localparam int CW   = dctd_pkg::COUNT_WIDTH;
	// candidates reach floor(sqrt(max)) + 1
	localparam int CAND_WIDTH = VALUE_WIDTH / 2 + 2;
	// the running square passes the value by one step at most
	localparam int SQ_W = VALUE_WIDTH + 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CAND_WIDTH-1:0]  cand_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   sq_eq_q;
	logic [CW-1:0]          cnt_q;

	logic                   out_vld_q;
	logic [CW-1:0]          out_cnt_q;
	logic                   out_prime_q;

	logic                   rem_start;
	dctd_pkg::rem_rsp_t     rem_rsp;
	logic [SQ_W-1:0]        val_ext;
	logic                   sq_gt;
	logic                   out_free;

	assign val_ext   = SQ_W'(val_q);
	assign sq_gt     = sq_q > val_ext;
	assign rem_start = (state_q == ST_CHECK) && !sq_gt;
	assign out_free  = !out_vld_q || rsp.ready;

	// Shared remainder unit: value % cand, one bit a cycle.
	dctd_rem_unit #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.CAND_WIDTH  (CAND_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (val_q),
		.divisor  (cand_q),
		.rsp      (rem_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_vld_q   <= 1'b0;
			out_cnt_q   <= '0;
			out_prime_q <= 1'b0;
		end else begin
			// load the output beat from a finished item, drop it once taken
			out_vld_q <= (state_q == ST_FIN && out_free) || (out_vld_q && !rsp.ready);
			if (state_q == ST_FIN && out_free) begin
				out_cnt_q   <= cnt_q;
				out_prime_q <= (val_q > VALUE_WIDTH'(1)) && (cnt_q == dctd_pkg::CNT_PAIR);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					// candidate beyond the root ends the search
					state_q <= sq_gt ? ST_FIN : ST_DIV;
				end
				ST_DIV: begin
					if (rem_rsp.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FIN: begin
					// hold the result until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: no reset, loaded on accept, advanced per candidate.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			val_q  <= req.value;
			cand_q <= CAND_WIDTH'(1);
			sq_q   <= SQ_W'(1);
			cnt_q  <= '0;
		end
		if (state_q == ST_CHECK) begin
			sq_eq_q <= (sq_q == val_ext);
		end
		if (state_q == ST_DIV && rem_rsp.done) begin
			if (rem_rsp.is_zero) begin
				cnt_q <= cnt_q + (sq_eq_q ? dctd_pkg::CNT_SQUARE : dctd_pkg::CNT_PAIR);
			end
			// advance: (c+1)^2 = c^2 + 2c + 1
			cand_q <= cand_q + CAND_WIDTH'(1);
			sq_q   <= sq_q + SQ_W'({cand_q, 1'b1});
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = out_vld_q;
	assign rsp.divisor_count = out_cnt_q;
	assign rsp.is_prime      = out_prime_q;

	`DCTD_ASSERT_IMP(a_done_in_div, clk, arst_n, rem_rsp.done, state_q == ST_DIV)
	`DCTD_ASSERT_NXT(a_accept_starts, clk, arst_n, req.valid && req.ready,
		state_q == ST_CHECK && cand_q == CAND_WIDTH'(1))
	`DCTD_ASSERT_IMP(a_prime_two, clk, arst_n, out_vld_q && out_prime_q,
		out_cnt_q == dctd_pkg::CNT_PAIR)
	`DCTD_ASSERT_NXT(a_fin_loads, clk, arst_n, state_q == ST_FIN && out_free,
		out_vld_q && state_q == ST_IDLE)

endmodule

FILE: hw/rtl/dctd_rem_unit.sv
module dctd_rem_unit #(
	parameter int VALUE_WIDTH = 31,
	parameter int CAND_WIDTH  = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [CAND_WIDTH-1:0]  divisor,
	output dctd_pkg::rem_rsp_t     rsp
);

	// Bit-serial restoring remainder: one dividend bit per cycle, MSB first.
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       bits_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [CAND_WIDTH-1:0]  dsr_q;
	logic [CAND_WIDTH-1:0]  rem_q;

	logic [CAND_WIDTH:0]    trial;
	logic [CAND_WIDTH:0]    diff;
	logic                   fits;

	assign trial = {rem_q, dvd_q[VALUE_WIDTH-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bits_q <= '0;
		end else begin
			// flag done for one cycle after the last dividend bit
			done_q <= busy_q && !start && (bits_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				bits_q <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				bits_q <= bits_q - CNT_W'(1);
				if (bits_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
			// remainder stays below the divisor, so the top bit drops
			rem_q <= fits ? diff[CAND_WIDTH-1:0] : trial[CAND_WIDTH-1:0];
		end
	end

	assign rsp.done    = done_q;
	assign rsp.is_zero = (rem_q == '0);

endmodule
